>>> sv/dvpf_pkg.sv
package dvpf_pkg;

  // Field and datapath widths
  localparam int VEL_W     = 24;
  localparam int GAIN_W    = 24;
  localparam int ERR_W     = 25;
  localparam int DER_W     = 26;
  localparam int EFF_W     = 32;
  localparam int SUM_W     = 36;
  localparam int MA_W      = 33;
  localparam int MB_W      = 26;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int LRAW_W    = 27;
  localparam int RGT_W     = 28;
  localparam int SPDC_W    = 9;
  localparam int SPD_W     = 8;
  localparam int DIR_W     = 2;
  localparam int CNT_W     = 4;
  localparam int ST_W      = 4;
  localparam int NUM_GAINS = 8;
  localparam int GIDX_W    = 3;
  localparam int CFG_IDX_W = 8;

  localparam int FRAME_REPEAT_DEF = 10;

  // Fixed-point constants
  localparam int GAIN_FRAC = 24;
  localparam int LRAW_SH   = 18;
  localparam int RIGHT_SH  = 17;
  localparam int MIX_L_K   = 2040;
  localparam int MIX_A_K   = 459;
  localparam int SPEED_MAX = 255;

  // Frame kinds
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_KEEP  = 1'b1;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_MIXED = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

  // Gain groups; register index is {group, mode}
  localparam logic [1:0] GRP_LKP = 2'd0;
  localparam logic [1:0] GRP_LKD = 2'd1;
  localparam logic [1:0] GRP_AKP = 2'd2;
  localparam logic [1:0] GRP_AKD = 2'd3;

  // Multiplier operations
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_LKP   = 3'd1;
  localparam logic [2:0] MUL_LKD   = 3'd2;
  localparam logic [2:0] MUL_AKP   = 3'd3;
  localparam logic [2:0] MUL_AKD   = 3'd4;
  localparam logic [2:0] MUL_L2040 = 3'd5;
  localparam logic [2:0] MUL_A459  = 3'd6;

  // Accumulator operations
  localparam logic [2:0] ACC_HOLD  = 3'd0;
  localparam logic [2:0] ACC_LOAD  = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_SUB   = 3'd3;
  localparam logic [2:0] ACC_RIGHT = 3'd4;

  typedef struct packed {
    logic       capture;
    logic       der_ld;
    logic [2:0] mul_op;
    logic [2:0] acc_op;
    logic       lin_upd;
    logic       ang_upd;
    logic       lraw_ld;
    logic       right_ld;
    logic       out_ld;
  } dvpf_cmd_t;

  function automatic logic [GAIN_W-1:0] gain_reset(input logic [GIDX_W-1:0] idx);
    logic [GAIN_W-1:0] g;
    case (idx)
      3'd0, 3'd1: g = 24'd268435;
      3'd2, 3'd3: g = 24'd96637;
      3'd4, 3'd5: g = 24'd100663;
      3'd6, 3'd7: g = 24'd25166;
      default:    g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [EFF_W-1:0] sat_eff(input logic signed [SUM_W-1:0] s);
    logic signed [EFF_W-1:0] r;
    if (s[SUM_W-1:EFF_W-1] == '0 || s[SUM_W-1:EFF_W-1] == '1) begin
      r = s[EFF_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(EFF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EFF_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SPDC_W-1:0] clamp_speed(input logic signed [RGT_W-1:0] x);
    logic signed [SPDC_W-1:0] r;
    if (x > RGT_W'(SPEED_MAX)) begin
      r = SPDC_W'(SPEED_MAX);
    end else if (x < -RGT_W'(SPEED_MAX)) begin
      r = -SPDC_W'(SPEED_MAX);
    end else begin
      r = x[SPDC_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/dvpf_ifs.sv
interface dvpf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dvpf_pkg::VEL_W-1:0]    target_linear;
  logic signed [dvpf_pkg::VEL_W-1:0]    target_angular;
  logic signed [dvpf_pkg::VEL_W-1:0]    measured_linear;
  logic signed [dvpf_pkg::VEL_W-1:0]    measured_angular;

  modport source (output valid, target_linear, target_angular, measured_linear,
                  measured_angular, input ready);
  modport sink (input valid, target_linear, target_angular, measured_linear,
                measured_angular, output ready);
endinterface

interface dvpf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             frame_kind;
  logic [dvpf_pkg::DIR_W-1:0]       direction;
  logic [dvpf_pkg::SPD_W-1:0]       left_speed;
  logic [dvpf_pkg::SPD_W-1:0]       right_speed;

  modport source (output valid, frame_kind, direction, left_speed, right_speed,
                  input ready);
  modport sink (input valid, frame_kind, direction, left_speed, right_speed,
                output ready);
endinterface

interface dvpf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dvpf_pkg::CFG_IDX_W-1:0]      index;
  logic [dvpf_pkg::GAIN_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/dvpf_ctrl.sv
module dvpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dvpf_pkg::dvpf_cmd_t cmd
);

  localparam logic [dvpf_pkg::ST_W-1:0] S_IDLE = 4'd0;
  localparam logic [dvpf_pkg::ST_W-1:0] S_LKP  = 4'd1;
  localparam logic [dvpf_pkg::ST_W-1:0] S_LKD  = 4'd2;
  localparam logic [dvpf_pkg::ST_W-1:0] S_LSUM = 4'd3;
  localparam logic [dvpf_pkg::ST_W-1:0] S_LUPD = 4'd4;
  localparam logic [dvpf_pkg::ST_W-1:0] S_AKD  = 4'd5;
  localparam logic [dvpf_pkg::ST_W-1:0] S_ASUM = 4'd6;
  localparam logic [dvpf_pkg::ST_W-1:0] S_AUPD = 4'd7;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M1   = 4'd8;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M2   = 4'd9;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M3   = 4'd10;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M4   = 4'd11;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M5   = 4'd12;
  localparam logic [dvpf_pkg::ST_W-1:0] S_M6   = 4'd13;
  localparam logic [dvpf_pkg::ST_W-1:0] S_OUT  = 4'd14;

  logic [dvpf_pkg::ST_W-1:0] state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the shared multiplier and accumulator
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_LKP;
      end
      S_LKP: begin
        cmd.der_ld = 1'b1;
        cmd.mul_op = dvpf_pkg::MUL_LKP;
        state_nxt  = S_LKD;
      end
      S_LKD: begin
        cmd.mul_op = dvpf_pkg::MUL_LKD;
        cmd.acc_op = dvpf_pkg::ACC_LOAD;
        state_nxt  = S_LSUM;
      end
      S_LSUM: begin
        cmd.acc_op = dvpf_pkg::ACC_ADD;
        state_nxt  = S_LUPD;
      end
      S_LUPD: begin
        cmd.lin_upd = 1'b1;
        cmd.mul_op  = dvpf_pkg::MUL_AKP;
        state_nxt   = S_AKD;
      end
      S_AKD: begin
        cmd.mul_op = dvpf_pkg::MUL_AKD;
        cmd.acc_op = dvpf_pkg::ACC_LOAD;
        state_nxt  = S_ASUM;
      end
      S_ASUM: begin
        cmd.acc_op = dvpf_pkg::ACC_ADD;
        state_nxt  = S_AUPD;
      end
      S_AUPD: begin
        cmd.ang_upd = 1'b1;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_op = dvpf_pkg::MUL_L2040;
        state_nxt  = S_M2;
      end
      S_M2: begin
        cmd.mul_op = dvpf_pkg::MUL_A459;
        cmd.acc_op = dvpf_pkg::ACC_LOAD;
        state_nxt  = S_M3;
      end
      S_M3: begin
        cmd.acc_op = dvpf_pkg::ACC_SUB;
        state_nxt  = S_M4;
      end
      S_M4: begin
        cmd.lraw_ld = 1'b1;
        state_nxt   = S_M5;
      end
      S_M5: begin
        cmd.acc_op = dvpf_pkg::ACC_RIGHT;
        state_nxt  = S_M6;
      end
      S_M6: begin
        cmd.right_ld = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LKP))
    else $error("accepted transaction did not start the sequence");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output step");

endmodule

>>> sv/dvpf_dp.sv
module dvpf_dp #(
  parameter int FRAME_REPEAT = dvpf_pkg::FRAME_REPEAT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dvpf_pkg::dvpf_cmd_t                 cmd,
  input  logic signed [dvpf_pkg::VEL_W-1:0]   target_linear,
  input  logic signed [dvpf_pkg::VEL_W-1:0]   target_angular,
  input  logic signed [dvpf_pkg::VEL_W-1:0]   measured_linear,
  input  logic signed [dvpf_pkg::VEL_W-1:0]   measured_angular,
  input  logic                                cfg_we,
  input  logic [dvpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dvpf_pkg::GAIN_W-1:0]         cfg_data,
  output logic                                frame_kind,
  output logic [dvpf_pkg::DIR_W-1:0]          direction,
  output logic [dvpf_pkg::SPD_W-1:0]          left_speed,
  output logic [dvpf_pkg::SPD_W-1:0]          right_speed
);

  // Gain registers
  logic [dvpf_pkg::GAIN_W-1:0]        gains_r [dvpf_pkg::NUM_GAINS];

  // Per-tick working registers
  logic                               mode_r;
  logic signed [dvpf_pkg::ERR_W-1:0]  lerr_r, aerr_r;
  logic signed [dvpf_pkg::DER_W-1:0]  lder_r, ader_r;
  logic signed [dvpf_pkg::PROD_W-1:0] prod_r, acc_r, acc_nxt;
  logic signed [dvpf_pkg::LRAW_W-1:0] lraw_r;
  logic signed [dvpf_pkg::RGT_W-1:0]  right_r;
  logic                               chg_r;

  // Controller state carried across ticks
  logic signed [dvpf_pkg::ERR_W-1:0]  lprev_r, aprev_r;
  logic signed [dvpf_pkg::EFF_W-1:0]  lin_eff_r, ang_eff_r;
  logic                               phase_r;
  logic [dvpf_pkg::CNT_W-1:0]         frames_r;

  // Output register
  logic                               kind_r;
  logic [dvpf_pkg::DIR_W-1:0]         dir_r;
  logic [dvpf_pkg::SPD_W-1:0]         left_r, right_byte_r;

  logic [1:0]                         grp;
  logic [dvpf_pkg::GAIN_W-1:0]        gain;
  logic signed [dvpf_pkg::MA_W-1:0]   mul_a;
  logic signed [dvpf_pkg::MB_W-1:0]   mul_b;
  logic signed [dvpf_pkg::PROD_W-1:0] prod_nxt;

  logic signed [dvpf_pkg::EFF_W-1:0]  eff_sel, eff_new;
  logic signed [dvpf_pkg::SUM_W-1:0]  eff_sum;

  logic signed [dvpf_pkg::PROD_W-1:0] x_adj, y_adj;

  logic signed [dvpf_pkg::SPDC_W-1:0] lc, rc, lmag, rmag;
  logic [dvpf_pkg::DIR_W-1:0]         dir_c;
  logic                               drive;

  // Pick the operands of the shared multiplier
  always_comb begin
    case (cmd.mul_op)
      dvpf_pkg::MUL_LKD: grp = dvpf_pkg::GRP_LKD;
      dvpf_pkg::MUL_AKP: grp = dvpf_pkg::GRP_AKP;
      dvpf_pkg::MUL_AKD: grp = dvpf_pkg::GRP_AKD;
      default:           grp = dvpf_pkg::GRP_LKP;
    endcase
    gain = gains_r[{grp, mode_r}];
    case (cmd.mul_op)
      dvpf_pkg::MUL_LKP: begin
        mul_a = dvpf_pkg::MA_W'(gain);
        mul_b = dvpf_pkg::MB_W'(lerr_r);
      end
      dvpf_pkg::MUL_LKD: begin
        mul_a = dvpf_pkg::MA_W'(gain);
        mul_b = lder_r;
      end
      dvpf_pkg::MUL_AKP: begin
        mul_a = dvpf_pkg::MA_W'(gain);
        mul_b = dvpf_pkg::MB_W'(aerr_r);
      end
      dvpf_pkg::MUL_AKD: begin
        mul_a = dvpf_pkg::MA_W'(gain);
        mul_b = ader_r;
      end
      dvpf_pkg::MUL_L2040: begin
        mul_a = dvpf_pkg::MA_W'(lin_eff_r);
        mul_b = dvpf_pkg::MB_W'(dvpf_pkg::MIX_L_K);
      end
      dvpf_pkg::MUL_A459: begin
        mul_a = dvpf_pkg::MA_W'(ang_eff_r);
        mul_b = dvpf_pkg::MB_W'(dvpf_pkg::MIX_A_K);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Accumulate products and form the mixer sums
  always_comb begin
    case (cmd.acc_op)
      dvpf_pkg::ACC_LOAD:  acc_nxt = prod_r;
      dvpf_pkg::ACC_ADD:   acc_nxt = acc_r + prod_r;
      dvpf_pkg::ACC_SUB:   acc_nxt = acc_r - prod_r;
      dvpf_pkg::ACC_RIGHT: acc_nxt = (dvpf_pkg::PROD_W'(lraw_r) <<< dvpf_pkg::RIGHT_SH)
                                     + prod_r;
      default:             acc_nxt = acc_r;
    endcase
  end

  // Add the floored increment to the effort and saturate
  always_comb begin
    eff_sel = cmd.ang_upd ? ang_eff_r : lin_eff_r;
    eff_sum = dvpf_pkg::SUM_W'(eff_sel)
            + dvpf_pkg::SUM_W'($signed(acc_r[dvpf_pkg::PROD_W-1:dvpf_pkg::GAIN_FRAC]));
    eff_new = dvpf_pkg::sat_eff(eff_sum);
  end

  // Divide toward zero by bias-then-shift
  assign x_adj = acc_r + (acc_r[dvpf_pkg::PROD_W-1]
                 ? dvpf_pkg::PROD_W'((64'd1 << dvpf_pkg::LRAW_SH) - 64'd1) : '0);
  assign y_adj = acc_r + (acc_r[dvpf_pkg::PROD_W-1]
                 ? dvpf_pkg::PROD_W'((64'd1 << dvpf_pkg::RIGHT_SH) - 64'd1) : '0);

  // Clamp the wheel speeds and derive direction
  always_comb begin
    lc   = dvpf_pkg::clamp_speed(dvpf_pkg::RGT_W'(lraw_r));
    rc   = dvpf_pkg::clamp_speed(right_r);
    lmag = lc;
    rmag = rc;
    if (lc < 0 && rc < 0) begin
      dir_c = dvpf_pkg::DIR_REV;
      lmag  = -lc;
      rmag  = -rc;
    end else if (lc > 0 && rc > 0) begin
      dir_c = dvpf_pkg::DIR_FWD;
    end else begin
      dir_c = dvpf_pkg::DIR_MIXED;
    end
    drive = !phase_r && (frames_r < dvpf_pkg::CNT_W'(FRAME_REPEAT));
  end

  // Control state: gains, efforts, previous errors and framing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dvpf_pkg::NUM_GAINS; i++) begin
        gains_r[i] <= dvpf_pkg::gain_reset(dvpf_pkg::GIDX_W'(i));
      end
      lprev_r   <= '0;
      aprev_r   <= '0;
      lin_eff_r <= '0;
      ang_eff_r <= '0;
      phase_r   <= 1'b0;
      frames_r  <= '0;
    end else begin
      if (cfg_we && cfg_index < dvpf_pkg::CFG_IDX_W'(dvpf_pkg::NUM_GAINS)) begin
        gains_r[cfg_index[dvpf_pkg::GIDX_W-1:0]] <= cfg_data;
      end
      if (cmd.lin_upd) begin
        lin_eff_r <= eff_new;
        lprev_r   <= lerr_r;
      end
      if (cmd.ang_upd) begin
        ang_eff_r <= eff_new;
        aprev_r   <= aerr_r;
      end
      if (cmd.out_ld) begin
        phase_r <= ~phase_r;
        if (chg_r) begin
          frames_r <= '0;
        end else if (drive) begin
          frames_r <= frames_r + 1'b1;
        end
      end
    end
  end

  // Working and output registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lerr_r <= dvpf_pkg::ERR_W'(target_linear) - dvpf_pkg::ERR_W'(measured_linear);
      aerr_r <= dvpf_pkg::ERR_W'(target_angular) - dvpf_pkg::ERR_W'(measured_angular);
      mode_r <= ~target_angular[dvpf_pkg::VEL_W-1];
      chg_r  <= 1'b0;
    end
    if (cmd.der_ld) begin
      lder_r <= dvpf_pkg::DER_W'(lerr_r) - dvpf_pkg::DER_W'(lprev_r);
      ader_r <= dvpf_pkg::DER_W'(aerr_r) - dvpf_pkg::DER_W'(aprev_r);
    end
    if (cmd.lin_upd) chg_r <= chg_r | (eff_new != lin_eff_r);
    if (cmd.ang_upd) chg_r <= chg_r | (eff_new != ang_eff_r);
    if (cmd.mul_op != dvpf_pkg::MUL_NONE) prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    if (cmd.lraw_ld) lraw_r <= x_adj[dvpf_pkg::LRAW_SH +: dvpf_pkg::LRAW_W];
    if (cmd.right_ld) right_r <= y_adj[dvpf_pkg::RIGHT_SH +: dvpf_pkg::RGT_W];
    if (cmd.out_ld) begin
      if (drive) begin
        kind_r       <= dvpf_pkg::KIND_DRIVE;
        dir_r        <= dir_c;
        left_r       <= lmag[dvpf_pkg::SPD_W-1:0];
        right_byte_r <= rmag[dvpf_pkg::SPD_W-1:0];
      end else begin
        kind_r       <= dvpf_pkg::KIND_KEEP;
        dir_r        <= dvpf_pkg::DIR_MIXED;
        left_r       <= '0;
        right_byte_r <= '0;
      end
    end
  end

  assign frame_kind  = kind_r;
  assign direction   = dir_r;
  assign left_speed  = left_r;
  assign right_speed = right_byte_r;

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= dvpf_pkg::CNT_W'(FRAME_REPEAT))
    else $error("drive frame count ran past its limit");

  a_keep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.out_ld) && kind_r == dvpf_pkg::KIND_KEEP) |->
      (dir_r == dvpf_pkg::DIR_MIXED && left_r == '0 && right_byte_r == '0))
    else $error("keepalive carries nonzero fields");

  a_fwd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.out_ld) && kind_r == dvpf_pkg::KIND_DRIVE &&
     dir_r == dvpf_pkg::DIR_FWD) |-> (left_r != '0 && right_byte_r != '0))
    else $error("forward frame with a zero wheel speed");

endmodule

>>> sv/diff_drive_velocity_pd_framer_top.sv
// Channel  Role    Handshake            Payload
// in_ch    sink    valid/ready          target/measured linear and angular, Q7.16
// out_ch   source  valid/ready          frame_kind, direction, left/right speed
// cfg_ch   sink    valid, ready tied 1  index (gain 0..7), data (Q0.24 gain)
//
// Each transaction, from acceptance to a valid result, is computed while a single shared
// 33x26 multiplier runs four gain products and two mixer products in turn.
// The next transaction is accepted once the result sits in the output register, so
// transactions never overlap; a stalled sink holds that register and
// the sequencer waits at its last step.
// Reset (rst_n low, synchronous) restores the default gains and clears efforts,
// previous errors and the framing counters. Gain writes are taken every cycle.
module diff_drive_velocity_pd_framer_top #(
  parameter int FRAME_REPEAT = dvpf_pkg::FRAME_REPEAT_DEF
) (
  input logic   clk,
  input logic   rst_n,
  dvpf_in_if.sink    in_ch,
  dvpf_out_if.source out_ch,
  dvpf_cfg_if.sink   cfg_ch
);

  dvpf_pkg::dvpf_cmd_t cmd;
  logic                in_ready;
  logic                out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  dvpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dvpf_dp #(
    .FRAME_REPEAT (FRAME_REPEAT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .target_linear    (in_ch.target_linear),
    .target_angular   (in_ch.target_angular),
    .measured_linear  (in_ch.measured_linear),
    .measured_angular (in_ch.measured_angular),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .frame_kind       (out_ch.frame_kind),
    .direction        (out_ch.direction),
    .left_speed       (out_ch.left_speed),
    .right_speed      (out_ch.right_speed)
  );

endmodule

>>> tb/tb_diff_drive_velocity_pd_framer_top.sv
`timescale 1ns / 1ps

// One control tick as presented on the input channel
typedef struct packed {
  logic [dvpf_pkg::VEL_W-1:0] tgt_lin;
  logic [dvpf_pkg::VEL_W-1:0] tgt_ang;
  logic [dvpf_pkg::VEL_W-1:0] meas_lin;
  logic [dvpf_pkg::VEL_W-1:0] meas_ang;
} tick_t;

// One serial frame as presented on the result channel
typedef struct packed {
  logic                       frame_kind;
  logic [dvpf_pkg::DIR_W-1:0] direction;
  logic [dvpf_pkg::SPD_W-1:0] left_speed;
  logic [dvpf_pkg::SPD_W-1:0] right_speed;
} frame_t;

// Tracks gains, PD efforts and framing state; predicts the frame of each tick
class pd_frame_scoreboard;
  logic [dvpf_pkg::GAIN_W-1:0] gain [dvpf_pkg::NUM_GAINS];
  longint      prev_lin_err;
  longint      prev_ang_err;
  longint      lin_eff;
  longint      ang_eff;
  longint      last_lin_eff;
  longint      last_ang_eff;
  bit          keep_phase;
  int unsigned drive_count;
  int unsigned repeat_limit;
  frame_t      awaited_frames[$];

  function new(int unsigned limit);
    repeat_limit = limit;
    gain[0] = 24'd268435;
    gain[1] = 24'd268435;
    gain[2] = 24'd96637;
    gain[3] = 24'd96637;
    gain[4] = 24'd100663;
    gain[5] = 24'd100663;
    gain[6] = 24'd25166;
    gain[7] = 24'd25166;
    prev_lin_err = 0;
    prev_ang_err = 0;
    lin_eff      = 0;
    ang_eff      = 0;
    last_lin_eff = 0;
    last_ang_eff = 0;
    keep_phase   = 1'b0;
    drive_count  = 0;
  endfunction

  // Drop writes to indexes past the gain file
  function void write_gain(logic [dvpf_pkg::CFG_IDX_W-1:0] idx,
                           logic [dvpf_pkg::GAIN_W-1:0] val);
    if (idx < dvpf_pkg::NUM_GAINS) begin
      gain[idx[dvpf_pkg::GIDX_W-1:0]] = val;
    end
  endfunction

  // Exact kp*e + kd*(e - prev), floored down by the gain fraction
  function longint pd_increment(longint err, longint prev,
                                logic [dvpf_pkg::GAIN_W-1:0] kp,
                                logic [dvpf_pkg::GAIN_W-1:0] kd);
    longint der;
    der = err - prev;
    return (longint'(kp) * err + longint'(kd) * der) >>> dvpf_pkg::GAIN_FRAC;
  endfunction

  function longint sat_effort(longint s);
    longint hi;
    longint lo;
    hi = (longint'(1) << (dvpf_pkg::EFF_W - 1)) - 1;
    lo = -(longint'(1) << (dvpf_pkg::EFF_W - 1));
    if (s > hi) begin
      return hi;
    end else if (s < lo) begin
      return lo;
    end
    return s;
  endfunction

  function longint clamp_wheel(longint x);
    if (x > dvpf_pkg::SPEED_MAX) begin
      return dvpf_pkg::SPEED_MAX;
    end else if (x < -dvpf_pkg::SPEED_MAX) begin
      return -dvpf_pkg::SPEED_MAX;
    end
    return x;
  endfunction

  function void note_tick(tick_t t);
    longint     tl;
    longint     ta;
    longint     ml;
    longint     ma;
    longint     l_raw;
    longint     r_raw;
    longint     lsp;
    longint     rsp;
    logic       mode;
    logic [dvpf_pkg::DIR_W-1:0] dir;
    frame_t     f;
    tl = longint'($signed(t.tgt_lin));
    ta = longint'($signed(t.tgt_ang));
    ml = longint'($signed(t.meas_lin));
    ma = longint'($signed(t.meas_ang));
    mode = (ta < 0) ? 1'b0 : 1'b1;

    // Advance both PD accumulators with the gain set picked by the yaw sign
    lin_eff = sat_effort(lin_eff + pd_increment(tl - ml, prev_lin_err,
                                                gain[{dvpf_pkg::GRP_LKP, mode}],
                                                gain[{dvpf_pkg::GRP_LKD, mode}]));
    prev_lin_err = tl - ml;
    ang_eff = sat_effort(ang_eff + pd_increment(ta - ma, prev_ang_err,
                                                gain[{dvpf_pkg::GRP_AKP, mode}],
                                                gain[{dvpf_pkg::GRP_AKD, mode}]));
    prev_ang_err = ta - ma;

    // Mix into wheel speeds; division truncates toward zero
    l_raw = (longint'(dvpf_pkg::MIX_L_K) * lin_eff - longint'(dvpf_pkg::MIX_A_K) * ang_eff)
            / (longint'(1) << dvpf_pkg::LRAW_SH);
    r_raw = (l_raw * (longint'(1) << dvpf_pkg::RIGHT_SH)
             + longint'(dvpf_pkg::MIX_A_K) * ang_eff) / (longint'(1) << dvpf_pkg::RIGHT_SH);
    lsp = clamp_wheel(l_raw);
    rsp = clamp_wheel(r_raw);

    if (lsp < 0 && rsp < 0) begin
      dir = dvpf_pkg::DIR_REV;
      lsp = -lsp;
      rsp = -rsp;
    end else if (lsp > 0 && rsp > 0) begin
      dir = dvpf_pkg::DIR_FWD;
    end else begin
      dir = dvpf_pkg::DIR_MIXED;
    end

    // Pick drive frame or keepalive, then restart the repeat count on change
    if (!keep_phase && drive_count < repeat_limit) begin
      f.frame_kind  = dvpf_pkg::KIND_DRIVE;
      f.direction   = dir;
      f.left_speed  = dvpf_pkg::SPD_W'(lsp);
      f.right_speed = dvpf_pkg::SPD_W'(rsp);
      drive_count   = (drive_count + 1) & ((1 << dvpf_pkg::CNT_W) - 1);
    end else begin
      f.frame_kind  = dvpf_pkg::KIND_KEEP;
      f.direction   = dvpf_pkg::DIR_MIXED;
      f.left_speed  = '0;
      f.right_speed = '0;
    end
    keep_phase = !keep_phase;
    if (lin_eff != last_lin_eff || ang_eff != last_ang_eff) begin
      drive_count = 0;
    end
    last_lin_eff = lin_eff;
    last_ang_eff = ang_eff;
    awaited_frames.push_back(f);
  endfunction

  function bit check_frame(frame_t got, output string msg);
    frame_t want;
    bit     ok;
    if (awaited_frames.size() == 0) begin
      msg = $sformatf("frame with none awaited: kind %0d dir %0d left %0d right %0d",
                      got.frame_kind, got.direction, got.left_speed, got.right_speed);
      return 1'b0;
    end
    want = awaited_frames.pop_front();
    ok = (got.frame_kind == want.frame_kind) && (got.direction == want.direction) &&
         (got.left_speed == want.left_speed) && (got.right_speed == want.right_speed);
    msg = $sformatf("frame got kind %0d dir %0d left %0d right %0d, want %0d %0d %0d %0d",
                    got.frame_kind, got.direction, got.left_speed, got.right_speed,
                    want.frame_kind, want.direction, want.left_speed, want.right_speed);
    return ok;
  endfunction

  function int pending();
    return awaited_frames.size();
  endfunction
endclass

module tb_diff_drive_velocity_pd_framer_top;

  localparam int DRAIN_CYCLES = 40;
  localparam int VEL_HI       = (1 << (dvpf_pkg::VEL_W - 1)) - 1;
  localparam int VEL_LO       = -(1 << (dvpf_pkg::VEL_W - 1));

  // Error shapes of generated ticks
  localparam int ERR_NONE  = 0;
  localparam int ERR_SMALL = 1;
  localparam int ERR_MED   = 2;
  localparam int ERR_NOISE = 3;
  localparam int ERR_EDGE  = 4;

  // Gain loading styles
  localparam int GAINS_RANDOM = 0;
  localparam int GAINS_SPLIT  = 1;
  localparam int GAINS_ZERO   = 2;
  localparam int GAINS_FULL   = 3;

  localparam logic [dvpf_pkg::CFG_IDX_W-1:0] IDX_TOP = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;
  int   mismatch_count = 0;

  pd_frame_scoreboard wheel_sb = new(dvpf_pkg::FRAME_REPEAT_DEF);

  dvpf_in_if  in_ch ();
  dvpf_out_if out_ch ();
  dvpf_cfg_if cfg_ch ();

  diff_drive_velocity_pd_framer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Stall the result sink in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Predict on every accepted tick
  always @(posedge clk) begin : tick_mon
    tick_t t;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      t.tgt_lin  = in_ch.target_linear;
      t.tgt_ang  = in_ch.target_angular;
      t.meas_lin = in_ch.measured_linear;
      t.meas_ang = in_ch.measured_angular;
      wheel_sb.note_tick(t);
    end
  end

  // Check every accepted frame
  always @(posedge clk) begin : frame_mon
    frame_t f;
    string  msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      f.frame_kind  = out_ch.frame_kind;
      f.direction   = out_ch.direction;
      f.left_speed  = out_ch.left_speed;
      f.right_speed = out_ch.right_speed;
      if (!wheel_sb.check_frame(f, msg)) begin
        report_mismatch(msg);
      end
    end
  end

  function automatic logic [dvpf_pkg::VEL_W-1:0] rand24();
    return dvpf_pkg::VEL_W'($urandom);
  endfunction

  function automatic logic [dvpf_pkg::VEL_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return dvpf_pkg::VEL_W'(VEL_HI);
      1:       return dvpf_pkg::VEL_W'(VEL_LO);
      2:       return '0;
      3:       return '1;
      4:       return dvpf_pkg::VEL_W'(1);
      default: return rand24();
    endcase
  endfunction

  function automatic int clamp_vel(int v);
    return (v > VEL_HI) ? VEL_HI : ((v < VEL_LO) ? VEL_LO : v);
  endfunction

  function automatic tick_t mk_tick(int tl, int ta, int ml, int ma);
    tick_t t;
    t.tgt_lin  = dvpf_pkg::VEL_W'(tl);
    t.tgt_ang  = dvpf_pkg::VEL_W'(ta);
    t.meas_lin = dvpf_pkg::VEL_W'(ml);
    t.meas_ang = dvpf_pkg::VEL_W'(ma);
    return t;
  endfunction

  // Build a tick whose errors follow the requested shape
  function automatic tick_t make_tick(int kind);
    tick_t t;
    int    span;
    int    meas_l;
    int    meas_a;
    int    err_l;
    int    err_a;
    span = (kind == ERR_SMALL) ? 1024 : ((kind == ERR_MED) ? 131072 : 0);
    if (kind == ERR_NOISE) begin
      t = {rand24(), rand24(), rand24(), rand24()};
    end else if (kind == ERR_EDGE) begin
      t = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end else begin
      meas_l = int'($signed(rand24()));
      meas_a = int'($signed(rand24()));
      err_l  = (span == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
      err_a  = (span == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
      t = mk_tick(clamp_vel(meas_l + err_l), clamp_vel(meas_a + err_a), meas_l, meas_a);
    end
    return t;
  endfunction

  // Present one tick from a falling edge; return at the falling edge after acceptance
  task automatic send_tick(input tick_t t);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid            = 1'b1;
    in_ch.target_linear    = t.tgt_lin;
    in_ch.target_angular   = t.tgt_ang;
    in_ch.measured_linear  = t.meas_lin;
    in_ch.measured_angular = t.meas_ang;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_gain_reg(input logic [dvpf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dvpf_pkg::GAIN_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    wheel_sb.write_gain(idx, val);
    @(negedge clk);
  endtask

  // Write all eight gains in one style, plus writes that must be dropped
  task automatic load_gains(input int style);
    logic [dvpf_pkg::GAIN_W-1:0] val;
    for (int i = 0; i < dvpf_pkg::NUM_GAINS; i++) begin
      case (style)
        GAINS_SPLIT: val = (i % 2 == 0) ? dvpf_pkg::GAIN_W'($urandom_range(0, 65535))
                                        : dvpf_pkg::GAIN_W'($urandom);
        GAINS_ZERO:  val = '0;
        GAINS_FULL:  val = '1;
        default:     val = dvpf_pkg::GAIN_W'($urandom);
      endcase
      write_gain_reg(dvpf_pkg::CFG_IDX_W'(i), val);
    end
    write_gain_reg(IDX_TOP, dvpf_pkg::GAIN_W'($urandom));
    write_gain_reg(dvpf_pkg::CFG_IDX_W'($urandom_range(dvpf_pkg::NUM_GAINS, 255)),
                   dvpf_pkg::GAIN_W'($urandom));
    cfg_ch.valid = 1'b0;
  endtask

  // Let every awaited frame arrive, then let the pipeline settle
  task automatic wait_drained();
    while (wheel_sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random ticks, partly in held runs so efforts settle and the repeat limit is hit
  task automatic run_phase(input int n_ticks, input int max_run, input bit allow_idle);
    int    sent;
    int    len;
    int    sel;
    int    kind;
    tick_t t;
    sent = 0;
    while (sent < n_ticks) begin
      idle_on = allow_idle && ($urandom_range(0, 4) != 0);
      sel  = $urandom_range(0, 9);
      kind = (sel < 2) ? ERR_NONE : (sel < 5) ? ERR_SMALL : (sel < 7) ? ERR_MED :
             (sel < 9) ? ERR_NOISE : ERR_EDGE;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_run) : 1;
      t    = make_tick(kind);
      repeat (len) send_tick(t);
      sent += len;
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin : stim
    in_ch.valid            = 1'b0;
    in_ch.target_linear    = '0;
    in_ch.target_angular   = '0;
    in_ch.measured_linear  = '0;
    in_ch.measured_angular = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed ticks under the reset gains
    send_tick(mk_tick(0, 0, 0, 0));
    send_tick(mk_tick(VEL_HI, 0, 0, 0));
    send_tick(mk_tick(VEL_LO, 0, 0, 0));
    send_tick(mk_tick(0, VEL_HI, 0, 0));
    send_tick(mk_tick(0, VEL_LO, 0, 0));
    send_tick(mk_tick(0, -1, 0, 0));
    send_tick(mk_tick(VEL_HI, VEL_HI, VEL_LO, VEL_LO));
    send_tick(mk_tick(VEL_LO, VEL_LO, VEL_HI, VEL_HI));
    send_tick(mk_tick(VEL_HI, VEL_HI, VEL_HI, VEL_HI));
    send_tick(mk_tick(VEL_LO, VEL_LO, VEL_LO, VEL_LO));
    send_tick(mk_tick(-1, -1, -1, -1));
    repeat (3) send_tick(mk_tick(-65536, 0, 0, 0));
    repeat (3) send_tick(mk_tick(65536, 0, 0, 0));
    repeat (2) send_tick(mk_tick(0, 65536, 0, 0));
    repeat (2) send_tick(mk_tick(0, -65536, 0, 0));
    repeat (2) send_tick(mk_tick(0, 0, 0, 0));

    // Random phases across gain settings
    run_phase(160, 30, 1'b1);
    wait_drained();
    load_gains(GAINS_RANDOM);
    run_phase(160, 30, 1'b1);
    wait_drained();
    load_gains(GAINS_SPLIT);
    run_phase(160, 30, 1'b1);
    wait_drained();
    load_gains(GAINS_ZERO);
    run_phase(120, 30, 1'b1);
    wait_drained();
    load_gains(GAINS_FULL);
    run_phase(220, 160, 1'b1);
    wait_drained();
    load_gains(GAINS_RANDOM);
    run_phase(160, 30, 1'b0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> diff_drive_velocity_pd_framer_top.f
sv/dvpf_pkg.sv
sv/dvpf_ifs.sv
sv/dvpf_ctrl.sv
sv/dvpf_dp.sv
sv/diff_drive_velocity_pd_framer_top.sv
tb/tb_diff_drive_velocity_pd_framer_top.sv
